@@ sv/dnw_pkg.sv @@
// ----------------------------------------------------------------------------
// dnw_pkg
// Shared types and constants for the domain name text-to-wire converter.
// ----------------------------------------------------------------------------
package dnw_pkg;

  localparam int MAX_NAME_BYTES_DEF  = 255;
  localparam int MAX_LABEL_BYTES_DEF = 63;

  // Most results one item can cause
  localparam int MAX_RES = 4;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int IDX_W   = $clog2(MAX_RES);

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Escape progress
  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_BSL  = 2'd1;
  localparam logic [1:0] PH_DIG1 = 2'd2;
  localparam logic [1:0] PH_DIG2 = 2'd3;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] write_pos;
    logic [7:0] write_byte;
    logic       last;
    logic       error;
    logic [7:0] name_length;
  } res_t;

  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] lstart;
    logic [1:0] phase;
    logic [3:0] d1;
    logic [3:0] d2;
    logic       failed;
    logic       lead;
  } st_t;

  localparam st_t ST_RESET = '{pos: 8'd1, lstart: 8'd0, phase: PH_NONE, d1: 4'd0,
                               d2: 4'd0, failed: 1'b0, lead: 1'b0};

  typedef struct packed {
    st_t                      st;
    logic [CNT_W-1:0]         cnt;
    res_t [MAX_RES-1:0]       res;
  } ctx_t;

endpackage

@@ sv/domain_name_text_to_wire_core.sv @@
// ----------------------------------------------------------------------------
// domain_name_text_to_wire_core
// Presentation-format domain name to DNS wire format, one character per item.
// ----------------------------------------------------------------------------
// A user sees one input item per cycle as long as each item causes at most one
// buffer write and nothing stalls downstream: the converter state updates at
// acceptance and the writes of the item land in a small result register. An
// item causing n results (escape flushes, the end item) holds the register
// until all n have left; in_stall is high while more than one result is still
// waiting, or while the last one is stalled downstream. An item causing no
// result (a backslash, the first escape digits) leaves it empty. Each write is
// (pos, byte) into an outside name buffer; the end item's final result has
// last set and either error or the total wire length including the root byte.
module domain_name_text_to_wire_core #(
  parameter int MAX_NAME_BYTES  = dnw_pkg::MAX_NAME_BYTES_DEF,
  parameter int MAX_LABEL_BYTES = dnw_pkg::MAX_LABEL_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // character items
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_char_code,
  // buffer writes and end report
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_write_valid,
  output logic [7:0] out_write_pos,
  output logic [7:0] out_write_byte,
  output logic       out_last,
  output logic       out_error,
  output logic [7:0] out_name_length
);

  dnw_pkg::st_t                         st_r, st_nxt;
  logic [dnw_pkg::CNT_W-1:0]            step_cnt;
  dnw_pkg::res_t [dnw_pkg::MAX_RES-1:0] step_res;
  dnw_pkg::res_t                        cur;
  logic                                 room;
  logic                                 accept;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  // label / escape tracking, updated once per accepted item
  dnw_step #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES),
    .MAX_LABEL_BYTES(MAX_LABEL_BYTES)
  ) u_step (
    .st_i  (st_r),
    .kind_i(in_kind),
    .char_i(in_char_code),
    .st_o  (st_nxt),
    .cnt_o (step_cnt),
    .res_o (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dnw_pkg::ST_RESET;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // up to four results per item, drained one per cycle while out_stall is low
  dnw_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_i   (accept),
    .cnt_i    (step_cnt),
    .res_i    (step_res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_res  (cur),
    .room_o   (room)
  );

  assign out_write_valid = cur.write_valid;
  assign out_write_pos   = cur.write_pos;
  assign out_write_byte  = cur.write_byte;
  assign out_last        = cur.last;
  assign out_error       = cur.error;
  assign out_name_length = cur.name_length;

endmodule

@@ sv/dnw_step.sv @@
// ----------------------------------------------------------------------------
// dnw_step
// Next-state and result logic for one presentation character or end item.
// ----------------------------------------------------------------------------
module dnw_step #(
  parameter int MAX_NAME_BYTES  = dnw_pkg::MAX_NAME_BYTES_DEF,
  parameter int MAX_LABEL_BYTES = dnw_pkg::MAX_LABEL_BYTES_DEF
) (
  input  dnw_pkg::st_t                          st_i,
  input  logic                                  kind_i,
  input  logic [7:0]                            char_i,
  output dnw_pkg::st_t                          st_o,
  output logic [dnw_pkg::CNT_W-1:0]             cnt_o,
  output dnw_pkg::res_t [dnw_pkg::MAX_RES-1:0]  res_o
);

  localparam logic [8:0] MaxName  = 9'(MAX_NAME_BYTES);
  localparam logic [8:0] MaxLabel = 9'(MAX_LABEL_BYTES);

  function automatic dnw_pkg::ctx_t f_emit(dnw_pkg::ctx_t c, dnw_pkg::res_t r);
    dnw_pkg::ctx_t t;
    t = c;
    if (int'(t.cnt) < dnw_pkg::MAX_RES) begin
      t.res[t.cnt[dnw_pkg::IDX_W-1:0]] = r;
      t.cnt = t.cnt + 1'b1;
    end
    return t;
  endfunction

  function automatic dnw_pkg::ctx_t f_put_data(dnw_pkg::ctx_t c, logic [7:0] b);
    dnw_pkg::ctx_t t;
    dnw_pkg::res_t r;
    t = c;
    if (!t.st.failed) begin
      if ({1'b0, t.st.pos} >= MaxName) begin
        t.st.failed = 1'b1;
      end else begin
        r = '{write_valid: 1'b1, write_pos: t.st.pos, write_byte: b,
              last: 1'b0, error: 1'b0, name_length: 8'd0};
        t = f_emit(t, r);
        t.st.pos = t.st.pos + 8'd1;
      end
    end
    return t;
  endfunction

  function automatic dnw_pkg::ctx_t f_put_dot(dnw_pkg::ctx_t c);
    dnw_pkg::ctx_t t;
    dnw_pkg::res_t r;
    logic [8:0]    len;
    t = c;
    len = {1'b0, t.st.pos} - {1'b0, t.st.lstart} - 9'd1;
    if (!t.st.failed) begin
      if ({1'b0, t.st.pos} >= MaxName || {1'b0, t.st.pos} == {1'b0, t.st.lstart} + 9'd1) begin
        t.st.failed = 1'b1;
      end else if (len > MaxLabel) begin
        t.st.failed = 1'b1;
      end else begin
        r = '{write_valid: 1'b1, write_pos: t.st.lstart, write_byte: len[7:0],
              last: 1'b0, error: 1'b0, name_length: 8'd0};
        t = f_emit(t, r);
        t.st.lstart = t.st.pos;
        t.st.pos = t.st.pos + 8'd1;
      end
    end
    return t;
  endfunction

  function automatic dnw_pkg::ctx_t f_plain(dnw_pkg::ctx_t c, logic [7:0] ch);
    dnw_pkg::ctx_t t;
    t = c;
    if (ch == dnw_pkg::CH_BSL) begin
      t.st.phase = dnw_pkg::PH_BSL;
    end else if (ch == dnw_pkg::CH_DOT) begin
      t = f_put_dot(t);
    end else begin
      t = f_put_data(t, ch);
    end
    return t;
  endfunction

  function automatic dnw_pkg::ctx_t f_finish(dnw_pkg::ctx_t c);
    dnw_pkg::ctx_t t;
    dnw_pkg::res_t r;
    logic [8:0]    len;
    t = c;
    if (!t.st.failed && t.st.lead) begin
      r = '{write_valid: 1'b1, write_pos: 8'd0, write_byte: 8'd0,
            last: 1'b1, error: 1'b0, name_length: 8'd1};
      t = f_emit(t, r);
    end else begin
      if (!t.st.failed) begin
        case (t.st.phase)
          dnw_pkg::PH_BSL:  t.st.failed = 1'b1;
          dnw_pkg::PH_DIG1: t = f_put_data(t, dnw_pkg::CH_ZERO + {4'd0, t.st.d1});
          dnw_pkg::PH_DIG2: begin
            t = f_put_data(t, dnw_pkg::CH_ZERO + {4'd0, t.st.d1});
            t = f_put_data(t, dnw_pkg::CH_ZERO + {4'd0, t.st.d2});
          end
          default: ;
        endcase
      end
      len = {1'b0, t.st.pos} - {1'b0, t.st.lstart} - 9'd1;
      if (!t.st.failed && {1'b0, t.st.pos} != {1'b0, t.st.lstart} + 9'd1) begin
        if (len > MaxLabel) begin
          t.st.failed = 1'b1;
        end else begin
          r = '{write_valid: 1'b1, write_pos: t.st.lstart, write_byte: len[7:0],
                last: 1'b0, error: 1'b0, name_length: 8'd0};
          t = f_emit(t, r);
          t.st.lstart = t.st.pos;
        end
      end
      if (!t.st.failed && {1'b0, t.st.lstart} >= MaxName) begin
        t.st.failed = 1'b1;
      end
      if (t.st.failed) begin
        r = '{write_valid: 1'b0, write_pos: 8'd0, write_byte: 8'd0,
              last: 1'b1, error: 1'b1, name_length: 8'd0};
      end else begin
        r = '{write_valid: 1'b1, write_pos: t.st.lstart, write_byte: 8'd0,
              last: 1'b1, error: 1'b0, name_length: t.st.lstart + 8'd1};
      end
      t = f_emit(t, r);
    end
    return t;
  endfunction

  dnw_pkg::ctx_t ctx;
  logic          is_dig;
  logic [3:0]    dval;
  logic [9:0]    val;

  always_comb begin
    is_dig = (char_i >= dnw_pkg::CH_ZERO) && (char_i <= dnw_pkg::CH_NINE);
    dval   = 4'(char_i - dnw_pkg::CH_ZERO);
    val    = 10'(st_i.d1) * 10'd100 + 10'(st_i.d2) * 10'd10 + 10'(dval);
    ctx     = '0;
    ctx.st  = st_i;
    if (kind_i == dnw_pkg::KIND_END) begin
      ctx    = f_finish(ctx);
      ctx.st = dnw_pkg::ST_RESET;
    end else if (st_i.failed) begin
      // rejected name: characters are swallowed
    end else if (st_i.lead) begin
      ctx.st.failed = 1'b1;
    end else begin
      case (st_i.phase)
        dnw_pkg::PH_NONE: begin
          if (char_i == dnw_pkg::CH_DOT && st_i.pos == 8'd1) begin
            ctx.st.lead = 1'b1;
          end else begin
            ctx = f_plain(ctx, char_i);
          end
        end
        dnw_pkg::PH_BSL: begin
          if (is_dig) begin
            ctx.st.d1    = dval;
            ctx.st.phase = dnw_pkg::PH_DIG1;
          end else begin
            ctx.st.phase = dnw_pkg::PH_NONE;
            ctx = f_put_data(ctx, char_i);
          end
        end
        dnw_pkg::PH_DIG1: begin
          if (is_dig) begin
            ctx.st.d2    = dval;
            ctx.st.phase = dnw_pkg::PH_DIG2;
          end else begin
            ctx.st.phase = dnw_pkg::PH_NONE;
            ctx = f_put_data(ctx, dnw_pkg::CH_ZERO + {4'd0, st_i.d1});
            ctx = f_plain(ctx, char_i);
          end
        end
        default: begin
          ctx.st.phase = dnw_pkg::PH_NONE;
          if (is_dig && val <= 10'd255) begin
            ctx = f_put_data(ctx, val[7:0]);
          end else begin
            ctx = f_put_data(ctx, dnw_pkg::CH_ZERO + {4'd0, st_i.d1});
            ctx = f_put_data(ctx, dnw_pkg::CH_ZERO + {4'd0, st_i.d2});
            if (is_dig) begin
              ctx = f_put_data(ctx, char_i);
            end else begin
              ctx = f_plain(ctx, char_i);
            end
          end
        end
      endcase
    end
  end

  assign st_o  = ctx.st;
  assign cnt_o = ctx.cnt;
  assign res_o = ctx.res;

endmodule

@@ sv/dnw_outbuf.sv @@
// ----------------------------------------------------------------------------
// dnw_outbuf
// Result register: holds the writes of one item and hands them out in order.
// ----------------------------------------------------------------------------
module dnw_outbuf (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load_i,
  input  logic [dnw_pkg::CNT_W-1:0]             cnt_i,
  input  dnw_pkg::res_t [dnw_pkg::MAX_RES-1:0]  res_i,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output dnw_pkg::res_t                         out_res,
  output logic                                  room_o
);

  dnw_pkg::res_t [dnw_pkg::MAX_RES-1:0] buf_r;
  logic [dnw_pkg::CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [dnw_pkg::IDX_W-1:0]            head_r, head_nxt;
  logic                                 take;

  assign take      = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_res   = buf_r[head_r];
  // room for a new item once the last waiting result leaves
  assign room_o    = (cnt_r == '0) || (cnt_r == dnw_pkg::CNT_W'(1) && !out_stall);

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    if (load_i) begin
      cnt_nxt  = cnt_i;
      head_nxt = '0;
    end else if (take) begin
      cnt_nxt  = cnt_r - 1'b1;
      head_nxt = head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      head_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      buf_r <= res_i;
    end
  end

endmodule

@@ sv/dnw_checker.sv @@
// ----------------------------------------------------------------------------
// dnw_checker
// Port-level checks for the name converter, bound to the top level.
// ----------------------------------------------------------------------------
module dnw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_write_valid,
  input logic [7:0] out_write_pos,
  input logic [7:0] out_write_byte,
  input logic       out_last,
  input logic       out_error,
  input logic [7:0] out_name_length
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_write_pos) &&
    $stable(out_write_byte) && $stable(out_last) && $stable(out_error))
    else $error("stalled result changed");

  // input only waits behind a pending result
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // good end: root zero at the end, length counts it
  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !out_error |-> out_write_valid &&
    out_write_byte == 8'd0 && out_name_length == 8'(out_write_pos + 8'd1))
    else $error("bad root write or length");

  // error only on the final result, with no write
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && !out_write_valid && out_name_length == 8'd0)
    else $error("malformed error result");

  // every non-final result is a write
  a_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> out_last && out_error)
    else $error("empty result that is not an error");

endmodule

bind domain_name_text_to_wire_core dnw_checker u_dnw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_write_valid(out_write_valid),
  .out_write_pos  (out_write_pos),
  .out_write_byte (out_write_byte),
  .out_last       (out_last),
  .out_error      (out_error),
  .out_name_length(out_name_length)
);
